FILE: rtl/mfep_pkg.sv
// ---------------------------------------------------------------------------
// MIDI file event parser package
// Record kinds, error codes, parse phases and small decode helpers.
// ---------------------------------------------------------------------------
package mfep_pkg;

  localparam logic [3:0] KIND_FORMAT  = 4'd0;
  localparam logic [3:0] KIND_NTRK    = 4'd1;
  localparam logic [3:0] KIND_DIV     = 4'd2;
  localparam logic [3:0] KIND_CHAN    = 4'd3;
  localparam logic [3:0] KIND_META    = 4'd4;
  localparam logic [3:0] KIND_SYSEX   = 4'd5;
  localparam logic [3:0] KIND_PAYLOAD = 4'd6;
  localparam logic [3:0] KIND_EOT     = 4'd7;
  localparam logic [3:0] KIND_WARN    = 4'd8;
  localparam logic [3:0] KIND_FATAL   = 4'd9;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_TAG      = 4'd1;
  localparam logic [3:0] ERR_HLEN     = 4'd2;
  localparam logic [3:0] ERR_FORMAT   = 4'd3;
  localparam logic [3:0] ERR_ODD_DIV  = 4'd4;
  localparam logic [3:0] ERR_SMPTE    = 4'd5;
  localparam logic [3:0] ERR_META_LEN = 4'd6;
  localparam logic [3:0] ERR_META_TYP = 4'd7;
  localparam logic [3:0] ERR_STATUS   = 4'd8;
  localparam logic [3:0] ERR_VLQ      = 4'd9;

  localparam logic [7:0] META_EOT = 8'h2F;

  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [7:0] STATUS_META   = 8'hFF;

  typedef enum logic [17:0] {
    PH_HTAG    = 18'h00001,
    PH_HLEN    = 18'h00002,
    PH_FMT     = 18'h00004,
    PH_NTRK    = 18'h00008,
    PH_DIV     = 18'h00010,
    PH_TTAG    = 18'h00020,
    PH_TLEN    = 18'h00040,
    PH_DELTA   = 18'h00080,
    PH_STATUS  = 18'h00100,
    PH_CHDATA  = 18'h00200,
    PH_SYSLEN  = 18'h00400,
    PH_MTYPE   = 18'h00800,
    PH_MVAR    = 18'h01000,
    PH_MFIXLEN = 18'h02000,
    PH_MFIX    = 18'h04000,
    PH_PAYLOAD = 18'h08000,
    PH_SKIP    = 18'h10000,
    PH_DONE    = 18'h20000
  } phase_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [27:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  meta_type;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [39:0] meta_value;
    logic [15:0] header_value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [3:0]  error_code;
    logic        used_running_status;
  } record_t;

  // expected length byte of a fixed meta; bit 3 set when the type is not fixed
  function automatic logic [3:0] fixed_len(input logic [7:0] t);
    case (t)
      8'h20, 8'h21: fixed_len = 4'd1;
      8'h2F:        fixed_len = 4'd0;
      8'h51:        fixed_len = 4'd3;
      8'h54:        fixed_len = 4'd5;
      8'h58:        fixed_len = 4'd4;
      8'h59:        fixed_len = 4'd2;
      default:      fixed_len = 4'd8;
    endcase
  endfunction

  function automatic logic var_meta(input logic [7:0] t);
    var_meta = (t <= 8'h09) || (t == 8'h7F);
  endfunction

  function automatic logic one_data(input logic [7:0] s);
    one_data = (s[7:4] == 4'hC) || (s[7:4] == 4'hD);
  endfunction

endpackage

FILE: rtl/midi_file_event_parser_top.sv
// ---------------------------------------------------------------------------
// MIDI file event parser top level
// Standard MIDI file byte stream in, decoded event records out.
// ---------------------------------------------------------------------------
// One file byte is taken per cycle when in_stall is low; each byte gives at
// most one record, which goes from the input register through the core to
// the result register, or to the skid slot when the result register cannot
// take it. A two-entry output buffer holds records while out_stall is
// high; in_stall rises only once that buffer is full. After a fatal record,
// or once the last track has ended, bytes are still taken but give no record.
module midi_file_event_parser_top #(
  parameter int MAX_QUANTITY_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  record_kind,
  output logic [27:0] delta_time,
  output logic [7:0]  status_byte,
  output logic [7:0]  meta_type,
  output logic [7:0]  first_data,
  output logic [7:0]  second_data,
  output logic [39:0] meta_value,
  output logic [15:0] header_value,
  output logic [7:0]  payload_byte,
  output logic        payload_last,
  output logic [3:0]  error_code,
  output logic        used_running_status
);

  logic              byte_valid;
  logic [7:0]        byte_reg;
  logic              room;
  logic              rec_valid;
  mfep_pkg::record_t rec, orec;

  // a byte in the input register moves on only when the buffer has room
  assign in_stall = byte_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
      byte_reg   <= file_byte;
    end
  end

  mfep_core #(.MAX_QUANTITY_BYTES(MAX_QUANTITY_BYTES)) u_core (
    .clk(clk), .rst(rst), .step(byte_valid && room), .b(byte_reg),
    .rec_valid(rec_valid), .rec(rec)
  );

  mfep_outbuf u_buf (
    .clk(clk), .rst(rst), .in_valid(rec_valid), .in_rec(rec), .in_room(room),
    .out_valid(out_valid), .out_stall(out_stall), .out_rec(orec)
  );

  assign record_kind         = orec.record_kind;
  assign delta_time          = orec.delta_time;
  assign status_byte         = orec.status_byte;
  assign meta_type           = orec.meta_type;
  assign first_data          = orec.first_data;
  assign second_data         = orec.second_data;
  assign meta_value          = orec.meta_value;
  assign header_value        = orec.header_value;
  assign payload_byte        = orec.payload_byte;
  assign payload_last        = orec.payload_last;
  assign error_code          = orec.error_code;
  assign used_running_status = orec.used_running_status;

endmodule

FILE: rtl/mfep_core.sv
// ---------------------------------------------------------------------------
// MIDI file event parser core
// Parse state and next-state logic; one byte consumed per strobe.
// ---------------------------------------------------------------------------
module mfep_core #(
  parameter int MAX_QUANTITY_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           b,
  output logic                 rec_valid,
  output mfep_pkg::record_t    rec
);

  mfep_pkg::phase_t phase, phase_next;
  logic [2:0]  byte_counter, byte_counter_next;
  logic [15:0] tracks_left, tracks_left_next;
  logic [7:0]  running_status, running_status_next;
  logic [27:0] delta_acc, delta_acc_next;
  logic [2:0]  quantity_bytes, quantity_bytes_next;
  logic [7:0]  cur_status, cur_status_next;
  logic [7:0]  cur_meta, cur_meta_next;
  logic [27:0] bytes_left, bytes_left_next;
  logic [39:0] value_acc, value_acc_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        halted, halted_next;

  logic [2:0]  qb_inc;
  logic        vlq_more, vlq_long;
  logic [27:0] vlq_delta, vlq_val, bl_dec;
  logic [7:0]  tag_byte;
  logic [15:0] hv;
  logic [3:0]  flen;
  logic [3:0]  flen_b;

  always_comb begin
    qb_inc    = quantity_bytes + 3'd1;
    vlq_more  = b[7];
    vlq_long  = vlq_more && (qb_inc >= 3'(MAX_QUANTITY_BYTES));
    vlq_delta = {delta_acc[20:0], b[6:0]};
    vlq_val   = {value_acc[20:0], b[6:0]};
    bl_dec    = bytes_left - 28'd1;
    hv        = {held_byte, b};
    flen      = mfep_pkg::fixed_len(cur_meta);
    flen_b    = mfep_pkg::fixed_len(b);
    case (byte_counter[1:0])
      2'd0:    tag_byte = 8'h4D;
      2'd1:    tag_byte = 8'h54;
      2'd2:    tag_byte = (phase == mfep_pkg::PH_HTAG) ? 8'h68 : 8'h72;
      default: tag_byte = (phase == mfep_pkg::PH_HTAG) ? 8'h64 : 8'h6B;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    byte_counter_next   = byte_counter;
    tracks_left_next    = tracks_left;
    running_status_next = running_status;
    delta_acc_next      = delta_acc;
    quantity_bytes_next = quantity_bytes;
    cur_status_next     = cur_status;
    cur_meta_next       = cur_meta;
    bytes_left_next     = bytes_left;
    value_acc_next      = value_acc;
    held_byte_next      = held_byte;
    halted_next         = halted;
    rec_valid           = 1'b0;
    rec                 = '0;
    if (step && !halted && phase != mfep_pkg::PH_DONE) begin
      case (phase)
        mfep_pkg::PH_HTAG, mfep_pkg::PH_TTAG: begin
          if (b != tag_byte) begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
            rec.error_code = mfep_pkg::ERR_TAG; halted_next = 1'b1;
          end else if (byte_counter[1:0] == 2'd3) begin
            byte_counter_next = '0;
            value_acc_next = '0;
            phase_next = (phase == mfep_pkg::PH_HTAG) ? mfep_pkg::PH_HLEN
                                                      : mfep_pkg::PH_TLEN;
          end else begin
            byte_counter_next = byte_counter + 3'd1;
          end
        end
        mfep_pkg::PH_HLEN: begin
          value_acc_next = {value_acc[31:0], b};
          if (byte_counter[1:0] == 2'd3) begin
            byte_counter_next = '0;
            if ({value_acc[31:0], b} != 40'd6) begin
              rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
              rec.error_code = mfep_pkg::ERR_HLEN; halted_next = 1'b1;
            end else begin
              phase_next = mfep_pkg::PH_FMT;
            end
          end else begin
            byte_counter_next = byte_counter + 3'd1;
          end
        end
        mfep_pkg::PH_FMT, mfep_pkg::PH_NTRK, mfep_pkg::PH_DIV: begin
          if (byte_counter == 3'd0) begin
            held_byte_next = b;
            byte_counter_next = 3'd1;
          end else begin
            byte_counter_next = '0;
            rec_valid = 1'b1;
            rec.header_value = hv;
            if (phase == mfep_pkg::PH_FMT) begin
              if (hv > 16'd2) begin
                rec = '0; rec.record_kind = mfep_pkg::KIND_FATAL;
                rec.error_code = mfep_pkg::ERR_FORMAT; halted_next = 1'b1;
              end else begin
                rec.record_kind = mfep_pkg::KIND_FORMAT;
                phase_next = mfep_pkg::PH_NTRK;
              end
            end else if (phase == mfep_pkg::PH_NTRK) begin
              rec.record_kind = mfep_pkg::KIND_NTRK;
              tracks_left_next = hv;
              phase_next = mfep_pkg::PH_DIV;
            end else begin
              rec.record_kind = mfep_pkg::KIND_DIV;
              if (hv[15]) begin
                rec.header_value = 16'd120;
                rec.error_code = mfep_pkg::ERR_SMPTE;
              end else if (hv != 16'd96 && hv != 16'd120 && hv != 16'd240 &&
                           hv != 16'd360 && hv != 16'd480) begin
                rec.error_code = mfep_pkg::ERR_ODD_DIV;
              end
              phase_next = (tracks_left == 16'd0) ? mfep_pkg::PH_DONE
                                                  : mfep_pkg::PH_TTAG;
            end
          end
        end
        mfep_pkg::PH_TLEN: begin
          if (byte_counter[1:0] == 2'd3) begin
            byte_counter_next = 3'd4;
            phase_next = mfep_pkg::PH_DELTA;
            delta_acc_next = '0; quantity_bytes_next = '0;
          end else begin
            byte_counter_next = byte_counter + 3'd1;
          end
        end
        mfep_pkg::PH_DELTA: begin
          delta_acc_next = vlq_delta;
          quantity_bytes_next = vlq_more ? qb_inc : 3'd0;
          if (vlq_long) begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
            rec.error_code = mfep_pkg::ERR_VLQ; halted_next = 1'b1;
          end else if (!vlq_more) begin
            phase_next = mfep_pkg::PH_STATUS;
          end
        end
        mfep_pkg::PH_STATUS: begin
          if (!b[7]) begin
            if (running_status < 8'h80 || running_status > 8'hEF) begin
              rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
              rec.error_code = mfep_pkg::ERR_STATUS; halted_next = 1'b1;
            end else begin
              cur_status_next = running_status;
              if (mfep_pkg::one_data(running_status)) begin
                rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_CHAN;
                rec.delta_time = delta_acc; rec.status_byte = running_status;
                rec.first_data = b; rec.used_running_status = 1'b1;
                byte_counter_next = 3'd4;
                phase_next = mfep_pkg::PH_DELTA;
                delta_acc_next = '0; quantity_bytes_next = '0;
              end else begin
                held_byte_next = b;
                byte_counter_next = 3'd5;
                phase_next = mfep_pkg::PH_CHDATA;
              end
            end
          end else if (b <= 8'hEF) begin
            cur_status_next = b; running_status_next = b;
            byte_counter_next = '0; phase_next = mfep_pkg::PH_CHDATA;
          end else if (b == mfep_pkg::STATUS_SYSEX || b == mfep_pkg::STATUS_ESCAPE) begin
            cur_status_next = b; cur_meta_next = '0; running_status_next = '0;
            value_acc_next = '0; quantity_bytes_next = '0;
            phase_next = mfep_pkg::PH_SYSLEN;
          end else if (b == mfep_pkg::STATUS_META) begin
            cur_status_next = b; running_status_next = '0;
            phase_next = mfep_pkg::PH_MTYPE;
          end else begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
            rec.error_code = mfep_pkg::ERR_STATUS; halted_next = 1'b1;
          end
        end
        mfep_pkg::PH_CHDATA: begin
          if (byte_counter[1:0] == 2'd0 && !mfep_pkg::one_data(cur_status)) begin
            held_byte_next = b;
            byte_counter_next = {byte_counter[2], 2'b01};
          end else begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_CHAN;
            rec.delta_time = delta_acc; rec.status_byte = cur_status;
            rec.used_running_status = byte_counter[2];
            if (byte_counter[1:0] == 2'd0) begin
              rec.first_data = b;
            end else begin
              rec.first_data = held_byte; rec.second_data = b;
            end
            phase_next = mfep_pkg::PH_DELTA;
            delta_acc_next = '0; quantity_bytes_next = '0;
          end
        end
        mfep_pkg::PH_SYSLEN, mfep_pkg::PH_MVAR: begin
          value_acc_next = {12'd0, vlq_val};
          quantity_bytes_next = vlq_more ? qb_inc : 3'd0;
          if (vlq_long) begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
            rec.error_code = mfep_pkg::ERR_VLQ; halted_next = 1'b1;
          end else if (!vlq_more) begin
            if (phase == mfep_pkg::PH_MVAR && !mfep_pkg::var_meta(cur_meta)) begin
              if (vlq_val == 28'd0) begin
                phase_next = mfep_pkg::PH_DELTA;
                delta_acc_next = '0;
              end else begin
                bytes_left_next = vlq_val; phase_next = mfep_pkg::PH_SKIP;
              end
            end else begin
              rec_valid = 1'b1;
              rec.record_kind = (phase == mfep_pkg::PH_SYSLEN) ?
                                mfep_pkg::KIND_SYSEX : mfep_pkg::KIND_META;
              rec.delta_time = delta_acc; rec.status_byte = cur_status;
              rec.meta_type = cur_meta; rec.meta_value = {12'd0, vlq_val};
              delta_acc_next = '0;
              if (vlq_val == 28'd0) begin
                phase_next = mfep_pkg::PH_DELTA;
              end else begin
                bytes_left_next = vlq_val; phase_next = mfep_pkg::PH_PAYLOAD;
              end
            end
          end
        end
        mfep_pkg::PH_MTYPE: begin
          cur_meta_next = b; value_acc_next = '0; quantity_bytes_next = '0;
          if (!flen_b[3]) begin
            phase_next = mfep_pkg::PH_MFIXLEN;
          end else begin
            phase_next = mfep_pkg::PH_MVAR;
            if (!mfep_pkg::var_meta(b)) begin
              rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_WARN;
              rec.delta_time = delta_acc; rec.status_byte = mfep_pkg::STATUS_META;
              rec.meta_type = b; rec.error_code = mfep_pkg::ERR_META_TYP;
              delta_acc_next = '0;
            end
          end
        end
        mfep_pkg::PH_MFIXLEN: begin
          if (flen[3] || b != {4'd0, flen}) begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_FATAL;
            rec.error_code = mfep_pkg::ERR_META_LEN; halted_next = 1'b1;
          end else if (flen == 4'd0) begin
            // end of track
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_EOT;
            rec.delta_time = delta_acc; rec.status_byte = mfep_pkg::STATUS_META;
            rec.meta_type = mfep_pkg::META_EOT;
            tracks_left_next = tracks_left - 16'd1;
            delta_acc_next = '0; quantity_bytes_next = '0;
            byte_counter_next = '0;
            phase_next = (tracks_left == 16'd1) ? mfep_pkg::PH_DONE
                                                : mfep_pkg::PH_TTAG;
          end else begin
            bytes_left_next = {24'd0, flen};
            value_acc_next = '0; phase_next = mfep_pkg::PH_MFIX;
          end
        end
        mfep_pkg::PH_MFIX: begin
          value_acc_next = {value_acc[31:0], b};
          bytes_left_next = bl_dec;
          if (bl_dec == 28'd0) begin
            rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_META;
            rec.delta_time = delta_acc; rec.status_byte = mfep_pkg::STATUS_META;
            rec.meta_type = cur_meta; rec.meta_value = {value_acc[31:0], b};
            phase_next = mfep_pkg::PH_DELTA;
            delta_acc_next = '0; quantity_bytes_next = '0;
          end
        end
        mfep_pkg::PH_PAYLOAD: begin
          bytes_left_next = bl_dec;
          rec_valid = 1'b1; rec.record_kind = mfep_pkg::KIND_PAYLOAD;
          rec.status_byte = cur_status; rec.meta_type = cur_meta;
          rec.payload_byte = b; rec.payload_last = (bl_dec == 28'd0);
          if (bl_dec == 28'd0) begin
            phase_next = mfep_pkg::PH_DELTA;
            delta_acc_next = '0; quantity_bytes_next = '0;
          end
        end
        mfep_pkg::PH_SKIP: begin
          bytes_left_next = bl_dec;
          if (bl_dec == 28'd0) begin
            phase_next = mfep_pkg::PH_DELTA;
            delta_acc_next = '0; quantity_bytes_next = '0;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mfep_pkg::PH_HTAG;
      byte_counter   <= '0;
      tracks_left    <= '0;
      running_status <= '0;
      delta_acc      <= '0;
      quantity_bytes <= '0;
      cur_status     <= '0;
      cur_meta       <= '0;
      bytes_left     <= '0;
      value_acc      <= '0;
      held_byte      <= '0;
      halted         <= 1'b0;
    end else begin
      phase          <= phase_next;
      byte_counter   <= byte_counter_next;
      tracks_left    <= tracks_left_next;
      running_status <= running_status_next;
      delta_acc      <= delta_acc_next;
      quantity_bytes <= quantity_bytes_next;
      cur_status     <= cur_status_next;
      cur_meta       <= cur_meta_next;
      bytes_left     <= bytes_left_next;
      value_acc      <= value_acc_next;
      held_byte      <= held_byte_next;
      halted         <= halted_next;
    end
  end

endmodule

FILE: rtl/mfep_outbuf.sv
// ---------------------------------------------------------------------------
// MIDI file event parser output buffer
// Result register with a skid slot; the input side waits only when both hold.
// ---------------------------------------------------------------------------
module mfep_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mfep_pkg::record_t in_rec,
  output logic              in_room,
  output logic              out_valid,
  input  logic              out_stall,
  output mfep_pkg::record_t out_rec
);

  logic              skid_valid;
  mfep_pkg::record_t skid_rec;

  // room while the skid slot is free
  assign in_room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_rec    <= skid_rec;
        out_valid  <= 1'b1;
        skid_valid <= in_valid;
        skid_rec   <= in_rec;
      end else begin
        out_rec   <= in_rec;
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
      skid_rec   <= in_rec;
    end
  end

endmodule
